>>> rtl/key_press_event_classifier_top_macros.svh
// assertion macros used by the key press event classifier top level
// expects clk_i and rst_ni in the scope of each use
`ifndef KEY_PRESS_EVENT_CLASSIFIER_TOP_MACROS_SVH
`define KEY_PRESS_EVENT_CLASSIFIER_TOP_MACROS_SVH

// checked on every rising edge outside reset
`define KPE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every rising edge, reset included
`define KPE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/kpe_pkg.sv
// types, codes and defaults for the key press event classifier
// no dependencies; used by every module of the block
`default_nettype none

package kpe_pkg;

  localparam int unsigned NumKeysDef    = 8;
  localparam int unsigned KeyW          = 3;
  localparam int unsigned TimeW         = 32;
  localparam int unsigned TicksW        = 16;
  localparam int unsigned CfgIdxW       = 2;
  localparam int unsigned InDataW       = 40;
  localparam int unsigned OutDataW      = 8;

  localparam logic [TicksW-1:0] DebounceDef = 16'd20;
  localparam logic [TicksW-1:0] LongDef     = 16'd1000;
  localparam logic [TicksW-1:0] WindowDef   = 16'd300;

  typedef enum logic [2:0] {
    EV_RELEASE = 3'd0,
    EV_PRESS   = 3'd1,
    EV_LONG    = 3'd2,
    EV_SHORT   = 3'd3,
    EV_DOUBLE  = 3'd4
  } kpe_event_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_LONG     = 2'd1,
    REG_WINDOW   = 2'd2
  } kpe_reg_e;

  typedef struct packed {
    logic [TicksW-1:0] debounce;
    logic [TicksW-1:0] long_press;
    logic [TicksW-1:0] window;
  } kpe_cfg_t;

  typedef struct packed {
    kpe_event_e       last_event;
    logic [TimeW-1:0] debounce_start;
    logic [TimeW-1:0] long_start;
    logic [TimeW-1:0] last_short_time;
  } kpe_entry_t;

endpackage

`default_nettype wire

>>> rtl/key_press_event_classifier_top.sv
// key press event classifier top level: stream ports, config registers, pipeline
// depends on kpe_pkg, kpe_state_mem, kpe_classify and the macros header
//
// one item in on s_axis gives one item out on m_axis: the key index and its event
// (release, press, long press, short press, double press). per-key state sits in
// a memory of NUM_KEYS entries, read when the item is taken and written back
// from the compute stage when the item moves on to the output register, with
// forwarding when consecutive items hit the same key.
// an accepted item passes the compute stage register, then the output register.
// throughput: one item per cycle while m_axis_tready stays high; the limit is the
// single read-modify-write of the state memory per cycle.
// the config channel (cfg_*) is always ready; registers: 0 debounce, 1 long press,
// 2 double window, 16 bit each. other indexes are dropped.
// reset: config returns to 20 / 1000 / 300 and every key reads back as released
// with all times unset, with no clearing pass.
// stall: when m_axis_tready is low the output register holds, one more item
// waits in the compute stage, and s_axis_tready then drops.
`default_nettype none
`include "key_press_event_classifier_top_macros.svh"

module key_press_event_classifier_top #(
  parameter int unsigned NUM_KEYS = kpe_pkg::NumKeysDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // key_index [2:0], pressed [3], time_now [35:4], zero [39:36]
  input  wire logic [kpe_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // key_out [2:0], event_res [5:3], zero [7:6]
  output logic      [kpe_pkg::OutDataW-1:0]  m_axis_tdata,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [kpe_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [kpe_pkg::TicksW-1:0]    cfg_data_i
);
  import kpe_pkg::*;

  localparam int unsigned AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  logic [KeyW-1:0]  in_key;
  logic             in_pressed;
  logic [TimeW-1:0] in_time;
  logic             in_range;
  logic             s_accept;
  logic             s1_adv;

  logic             s1_v_q;
  logic [KeyW-1:0]  s1_key_q;
  logic             s1_pressed_q;
  logic [TimeW-1:0] s1_time_q;
  logic             s1_inr_q;

  logic             m_v_q;
  logic [KeyW-1:0]  m_key_q;
  kpe_event_e       m_ev_q;

  kpe_cfg_t         cfg_q;
  kpe_entry_t       rd_entry;
  kpe_entry_t       wr_entry;
  kpe_event_e       s1_event;

  assign in_key     = s_axis_tdata[KeyW-1:0];
  assign in_pressed = s_axis_tdata[KeyW];
  assign in_time    = s_axis_tdata[KeyW+TimeW:KeyW+1];
  assign in_range   = (32'(in_key) < NUM_KEYS);

  assign s1_adv        = s1_v_q && (!m_v_q || m_axis_tready);
  assign s_axis_tready = !s1_v_q || s1_adv;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s_accept) begin
      s1_v_q <= 1'b1;
    end else if (s1_adv) begin
      s1_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      s1_key_q     <= in_key;
      s1_pressed_q <= in_pressed;
      s1_time_q    <= in_time;
      s1_inr_q     <= in_range;
    end
  end

  kpe_state_mem #(
    .NUM_KEYS (NUM_KEYS),
    .AW       (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (s_accept && in_range),
    .ra_i    (AW'(in_key)),
    .we_i    (s1_adv && s1_inr_q),
    .wa_i    (AW'(s1_key_q)),
    .wd_i    (wr_entry),
    .rdata_o (rd_entry)
  );

  kpe_classify u_classify (
    .entry_i    (rd_entry),
    .cfg_i      (cfg_q),
    .in_range_i (s1_inr_q),
    .pressed_i  (s1_pressed_q),
    .time_i     (s1_time_q),
    .event_o    (s1_event),
    .entry_o    (wr_entry)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= 1'b0;
    end else if (s1_adv) begin
      m_v_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      m_key_q <= s1_key_q;
      m_ev_q  <= s1_event;
    end
  end

  assign m_axis_tvalid = m_v_q;
  assign m_axis_tdata  = {{(OutDataW-2*KeyW){1'b0}}, m_ev_q, m_key_q};

  // config registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce   <= DebounceDef;
      cfg_q.long_press <= LongDef;
      cfg_q.window     <= WindowDef;
    end else if (cfg_valid_i) begin
      unique case (kpe_reg_e'(cfg_index_i))
        REG_DEBOUNCE: cfg_q.debounce   <= cfg_data_i;
        REG_LONG:     cfg_q.long_press <= cfg_data_i;
        REG_WINDOW:   cfg_q.window     <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  `KPE_ASSERT(a_accept_fills_s1, s_accept |=> s1_v_q, "accepted item missing in compute stage")
  `KPE_ASSERT(a_adv_fills_out, s1_adv |=> m_v_q, "computed item missing in output register")
  `KPE_ASSERT(a_oob_release, (m_v_q && (32'(m_key_q) >= NUM_KEYS)) |-> (m_ev_q == EV_RELEASE), "unknown key gave an event other than release")
  `KPE_ASSERT_ALWAYS(a_empty_ready, !s1_v_q |-> s_axis_tready, "input stalled with empty compute stage")

endmodule

`default_nettype wire

>>> rtl/kpe_state_mem.sv
// per-key state memory: synchronous read, valid bits for reset, write forwarding
// depends on kpe_pkg
`default_nettype none

module kpe_state_mem #(
  parameter int unsigned NUM_KEYS = kpe_pkg::NumKeysDef,
  parameter int unsigned AW       = 3
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               re_i,
  input  wire logic [AW-1:0]      ra_i,
  input  wire logic               we_i,
  input  wire logic [AW-1:0]      wa_i,
  input  wire kpe_pkg::kpe_entry_t wd_i,
  output kpe_pkg::kpe_entry_t     rdata_o
);
  import kpe_pkg::*;

  kpe_entry_t          mem [NUM_KEYS];
  logic [NUM_KEYS-1:0] vld_q;
  kpe_entry_t          rd_q;
  logic                rd_vld_q;
  logic                fwd_q;
  kpe_entry_t          fwd_data_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wa_i] <= wd_i;
    end
    if (re_i) begin
      rd_q       <= mem[ra_i];
      fwd_data_q <= wd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
      fwd_q    <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[wa_i] <= 1'b1;
      end
      if (re_i) begin
        rd_vld_q <= vld_q[ra_i];
        fwd_q    <= we_i && (wa_i == ra_i);
      end
    end
  end

  always_comb begin
    if (fwd_q) begin
      rdata_o = fwd_data_q;
    end else if (rd_vld_q) begin
      rdata_o = rd_q;
    end else begin
      rdata_o = '0;
    end
  end

endmodule

`default_nettype wire

>>> rtl/kpe_classify.sv
// event decision and next per-key state for one sample
// depends on kpe_pkg
`default_nettype none

module kpe_classify (
  input  wire kpe_pkg::kpe_entry_t     entry_i,
  input  wire kpe_pkg::kpe_cfg_t       cfg_i,
  input  wire logic                    in_range_i,
  input  wire logic                    pressed_i,
  input  wire logic [kpe_pkg::TimeW-1:0] time_i,
  output kpe_pkg::kpe_event_e          event_o,
  output kpe_pkg::kpe_entry_t          entry_o
);
  import kpe_pkg::*;

  logic [TimeW-1:0] deb_w, long_w, win_w;
  logic [TimeW-1:0] d_db, d_ls, d_lst;
  logic             db_unset, ls_unset, lst_unset, prev_press, prev_rel;
  logic             deb_ok, long_ok;
  kpe_event_e       ev;
  kpe_entry_t       nxt;

  assign deb_w  = {{(TimeW-TicksW){1'b0}}, cfg_i.debounce};
  assign long_w = {{(TimeW-TicksW){1'b0}}, cfg_i.long_press};
  assign win_w  = {{(TimeW-TicksW){1'b0}}, cfg_i.window};

  assign db_unset   = (entry_i.debounce_start == '0);
  assign ls_unset   = (entry_i.long_start == '0);
  assign lst_unset  = (entry_i.last_short_time == '0);
  assign prev_press = (entry_i.last_event == EV_PRESS);
  assign prev_rel   = (entry_i.last_event == EV_RELEASE);

  assign d_db  = time_i - entry_i.debounce_start;
  assign d_ls  = time_i - entry_i.long_start;
  assign d_lst = time_i - entry_i.last_short_time;

  // a freshly set start time gives a difference of zero
  assign deb_ok  = db_unset ? (deb_w == '0) : (d_db >= deb_w);

  always_comb begin
    nxt     = entry_i;
    ev      = entry_i.last_event;
    long_ok = 1'b0;
    if (pressed_i) begin
      if (db_unset) begin
        nxt.debounce_start = time_i;
      end
      if (deb_ok) begin
        ev = EV_PRESS;
        if (ls_unset) begin
          nxt.long_start = time_i;
        end
      end
      if (deb_ok && ls_unset) begin
        long_ok = (long_w == '0);
      end else begin
        long_ok = (d_ls >= long_w);
      end
      if (prev_press && long_ok) begin
        ev = EV_LONG;
      end
    end else begin
      nxt.debounce_start = '0;
      ev = EV_RELEASE;
      if (prev_press) begin
        if (!lst_unset && (d_lst < win_w)) begin
          ev = EV_DOUBLE;
          nxt.last_short_time = '0;
        end else begin
          ev = EV_SHORT;
          nxt.last_short_time = time_i;
        end
      end
      if (prev_press) begin
        if (ev == EV_DOUBLE) begin
          if (time_i > win_w) begin
            nxt.last_short_time = '0;
          end
        end
      end else if (d_lst > win_w) begin
        nxt.last_short_time = '0;
      end
      if (prev_rel && (d_ls > long_w)) begin
        nxt.long_start = '0;
      end
    end
    nxt.last_event = ev;
    if (!in_range_i) begin
      ev = EV_RELEASE;
    end
  end

  assign event_o = ev;
  assign entry_o = nxt;

endmodule

`default_nettype wire
